FILE: hw/rtl/header_length_tail_frame_parser_assert.svh
// Assertion macros used by the checker of the frame parser.
`ifndef HEADER_LENGTH_TAIL_FRAME_PARSER_ASSERT_SVH
`define HEADER_LENGTH_TAIL_FRAME_PARSER_ASSERT_SVH

// Checked on every rising edge once reset is released.
`define HLTFP_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define HLTFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

FILE: hw/rtl/hltfp_pkg.sv
package hltfp_pkg;

    // Result kinds.
    typedef logic [1:0] kind_t;
    localparam kind_t KIND_BYTE  = 2'd0;
    localparam kind_t KIND_EMPTY = 2'd1;
    localparam kind_t KIND_BAD   = 2'd2;
    localparam kind_t KIND_LONG  = 2'd3;

    // Register indexes of the configuration port.
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_FIRST_HEADER  = 2'd0;
    localparam cfg_index_t CFG_SECOND_HEADER = 2'd1;
    localparam cfg_index_t CFG_TAIL          = 2'd2;

    // Register reset values.
    localparam logic [7:0] FIRST_HEADER_RESET  = 8'h55;
    localparam logic [7:0] SECOND_HEADER_RESET = 8'h11;
    localparam logic [7:0] TAIL_RESET          = 8'hAA;

    // Parser phases, one-hot.
    typedef enum logic [6:0] {
        PH_HUNT1   = 7'b0000001,
        PH_HUNT2   = 7'b0000010,
        PH_LENGTH  = 7'b0000100,
        PH_DATA    = 7'b0001000,
        PH_TAIL    = 7'b0010000,
        PH_EMIT_RD = 7'b0100000,
        PH_EMIT_WR = 7'b1000000
    } phase_t;

endpackage

FILE: hw/rtl/header_length_tail_frame_parser.sv
// Channel   Direction  Handshake            Payload
// s_        in         s_valid / s_ready    s_rx_byte
// m_        out        m_valid / m_ready    m_kind, m_payload_byte, m_last
// cfg_      in         cfg_valid / cfg_ready cfg_index, cfg_wdata
//
// An input beat that causes no result, or one single result, is handled as it is taken.
// A nonempty frame with a good tail bursts its payload out of the store, each byte
// by a store read and then an output load; input beats wait meanwhile.
// Reset (aresetn low at a clock edge) returns the parser to header hunting and
// restores the register defaults; the payload store needs no clearing pass.
// A stalled output holds its beat; header and payload bytes are still taken,
// while length and tail bytes wait until the output register is free.
module header_length_tail_frame_parser #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_rx_byte,
    output logic                    m_valid,
    input  logic                    m_ready,
    output hltfp_pkg::kind_t        m_kind,
    output logic [7:0]              m_payload_byte,
    output logic                    m_last,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  hltfp_pkg::cfg_index_t   cfg_index,
    input  logic [7:0]              cfg_wdata
);
    import hltfp_pkg::*;

    localparam int CW = $clog2(PAYLOAD_DEPTH + 1);
    localparam int AW = (PAYLOAD_DEPTH > 1) ? $clog2(PAYLOAD_DEPTH) : 1;

    // Configuration registers.
    logic [7:0] first_header_reg;
    logic [7:0] second_header_reg;
    logic [7:0] tail_reg;

    // Control state.
    phase_t       phase_reg, phase_next;
    logic [CW-1:0] length_reg, length_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] count_inc;

    // Output register.
    logic       m_valid_reg, m_valid_next;
    kind_t      kind_reg, kind_next;
    logic [7:0] payload_reg, payload_next;
    logic       last_reg, last_next;
    logic       out_load;

    // Payload store.
    logic [7:0]    store_mem [PAYLOAD_DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] mem_addr;
    logic          wr_en;
    logic          rd_en;

    logic s_fire;
    logic out_free;

    assign cfg_ready = 1'b1;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_header_reg  <= FIRST_HEADER_RESET;
            second_header_reg <= SECOND_HEADER_RESET;
            tail_reg          <= TAIL_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FIRST_HEADER:  first_header_reg  <= cfg_wdata;
                CFG_SECOND_HEADER: second_header_reg <= cfg_wdata;
                CFG_TAIL:          tail_reg          <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign count_inc = count_reg + 1'b1;
    assign mem_addr = count_reg[AW-1:0];

    // Bytes that can produce a result wait for a free output register.
    always_comb begin
        case (phase_reg)
            PH_HUNT1, PH_HUNT2, PH_DATA: s_ready = 1'b1;
            PH_LENGTH, PH_TAIL:          s_ready = out_free;
            default:                     s_ready = 1'b0;
        endcase
    end

    // Phase sequencing and result generation.
    always_comb begin
        phase_next   = phase_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg && !m_ready;
        kind_next    = kind_reg;
        payload_next = payload_reg;
        last_next    = last_reg;
        out_load     = 1'b0;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        case (phase_reg)
            PH_HUNT1: begin
                if (s_fire && s_rx_byte == first_header_reg) begin
                    phase_next = PH_HUNT2;
                end
            end
            PH_HUNT2: begin
                if (s_fire) begin
                    phase_next = (s_rx_byte == second_header_reg) ? PH_LENGTH : PH_HUNT1;
                end
            end
            PH_LENGTH: begin
                if (s_fire) begin
                    if (s_rx_byte > 8'(PAYLOAD_DEPTH)) begin
                        out_load     = 1'b1;
                        kind_next    = KIND_LONG;
                        payload_next = 8'd0;
                        last_next    = 1'b1;
                        length_next  = '0;
                        count_next   = '0;
                        phase_next   = PH_HUNT1;
                    end else begin
                        length_next = s_rx_byte[CW-1:0];
                        count_next  = '0;
                        phase_next  = (s_rx_byte == 8'd0) ? PH_TAIL : PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                if (s_fire) begin
                    wr_en      = 1'b1;
                    count_next = count_inc;
                    if (count_inc >= length_reg) begin
                        phase_next = PH_TAIL;
                    end
                end
            end
            PH_TAIL: begin
                if (s_fire) begin
                    count_next = '0;
                    if (s_rx_byte == tail_reg && length_reg != '0) begin
                        phase_next = PH_EMIT_RD;
                    end else begin
                        out_load     = 1'b1;
                        kind_next    = (s_rx_byte == tail_reg) ? KIND_EMPTY : KIND_BAD;
                        payload_next = 8'd0;
                        last_next    = 1'b1;
                        length_next  = '0;
                        phase_next   = PH_HUNT1;
                    end
                end
            end
            PH_EMIT_RD: begin
                rd_en      = 1'b1;
                phase_next = PH_EMIT_WR;
            end
            PH_EMIT_WR: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    kind_next    = KIND_BYTE;
                    payload_next = rd_data_reg;
                    last_next    = (count_inc == length_reg);
                    if (count_inc == length_reg) begin
                        length_next = '0;
                        count_next  = '0;
                        phase_next  = PH_HUNT1;
                    end else begin
                        count_next = count_inc;
                        phase_next = PH_EMIT_RD;
                    end
                end
            end
            default: begin
                length_next = '0;
                count_next  = '0;
                phase_next  = PH_HUNT1;
            end
        endcase
        if (out_load) begin
            m_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT1;
            length_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            length_reg  <= length_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output payload loads only with a new result.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg    <= kind_next;
            payload_reg <= payload_next;
            last_reg    <= last_next;
        end
    end

    // Store writes during the payload phase and reads during the burst;
    // the two never overlap, since input beats stall while bursting.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[mem_addr] <= s_rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = kind_reg;
    assign m_payload_byte = payload_reg;
    assign m_last         = last_reg;

endmodule

FILE: hw/rtl/hltfp_checker.sv
`include "header_length_tail_frame_parser_assert.svh"

module hltfp_checker (
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic [7:0]              s_rx_byte,
    input logic                    m_valid,
    input logic                    m_ready,
    input hltfp_pkg::kind_t        m_kind,
    input logic [7:0]              m_payload_byte,
    input logic                    m_last,
    input logic                    cfg_valid,
    input logic                    cfg_ready,
    input hltfp_pkg::cfg_index_t   cfg_index,
    input logic [7:0]              cfg_wdata
);
    import hltfp_pkg::*;

    // A stalled result beat holds its contents.
    `HLTFP_ASSERT_RUN(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_payload_byte) && $stable(m_last)), "stalled result beat changed")

    // Status results stand alone and end their input's results.
    `HLTFP_ASSERT_RUN(a_status_last, (m_valid && m_kind != KIND_BYTE) |-> m_last, "status result without last")

    // Status results carry a zero byte.
    `HLTFP_ASSERT_RUN(a_status_zero, (m_valid && m_kind != KIND_BYTE) |-> (m_payload_byte == 8'd0), "status result with nonzero byte")

    // No input beat is taken while a payload burst is still running.
    `HLTFP_ASSERT_RUN(a_burst_blocks, (m_valid && m_kind == KIND_BYTE && !m_last) |-> !s_ready, "input taken during payload burst")

    // Reset leaves no result pending.
    `HLTFP_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind header_length_tail_frame_parser hltfp_checker u_hltfp_checker (.*);

FILE: tb/hltfp_frame_monitor.sv
`timescale 1ns / 1ps

// Watches the input, configuration and result channels of the frame parser.
// It keeps its own model of the parser and compares every result beat against
// the oldest beat still owed.
module hltfp_frame_monitor #(
    parameter int PAYLOAD_DEPTH = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [7:0]            s_rx_byte,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  hltfp_pkg::kind_t      m_kind,
    input  logic [7:0]            m_payload_byte,
    input  logic                  m_last,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  hltfp_pkg::cfg_index_t cfg_index,
    input  logic [7:0]            cfg_wdata,
    output int                    mismatch_count,
    output int                    beats_outstanding
);
    import hltfp_pkg::*;

    typedef enum logic [2:0] {
        HUNT_FIRST,
        HUNT_SECOND,
        TAKE_LENGTH,
        TAKE_PAYLOAD,
        TAKE_TAIL
    } parse_state_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        logic       last;
    } frame_beat_t;

    frame_beat_t  owed_beats[$];
    frame_beat_t  want;
    parse_state_t parse_state;
    logic [7:0]   first_hdr;
    logic [7:0]   second_hdr;
    logic [7:0]   tail_val;
    int           frame_len;
    int           bytes_held;
    logic [7:0]   payload_mem [PAYLOAD_DEPTH];
    int           errors = 0;

    function automatic void owe_beat(kind_t kind, logic [7:0] data, logic last);
        frame_beat_t beat;
        beat.kind = kind;
        beat.payload_byte = data;
        beat.last = last;
        owed_beats.push_back(beat);
    endfunction

    function automatic void restart_hunt();
        parse_state = HUNT_FIRST;
        frame_len = 0;
        bytes_held = 0;
    endfunction

    // Advances the parser by one received byte and queues the beats it owes.
    function automatic void parse_rx_byte(logic [7:0] b);
        int k;
        case (parse_state)
            HUNT_FIRST: begin
                if (b == first_hdr) parse_state = HUNT_SECOND;
            end
            HUNT_SECOND: begin
                // A wrong second byte is not retried as a first header byte.
                parse_state = (b == second_hdr) ? TAKE_LENGTH : HUNT_FIRST;
            end
            TAKE_LENGTH: begin
                if (b > PAYLOAD_DEPTH) begin
                    owe_beat(KIND_LONG, 8'h00, 1'b1);
                    restart_hunt();
                end else begin
                    frame_len = int'(b);
                    bytes_held = 0;
                    parse_state = (b == 0) ? TAKE_TAIL : TAKE_PAYLOAD;
                end
            end
            TAKE_PAYLOAD: begin
                if (bytes_held < PAYLOAD_DEPTH) begin
                    payload_mem[bytes_held] = b;
                    bytes_held++;
                end
                if (bytes_held >= frame_len) parse_state = TAKE_TAIL;
            end
            TAKE_TAIL: begin
                if (b != tail_val) begin
                    owe_beat(KIND_BAD, 8'h00, 1'b1);
                end else if (frame_len == 0) begin
                    owe_beat(KIND_EMPTY, 8'h00, 1'b1);
                end else begin
                    for (k = 0; k < frame_len && k < PAYLOAD_DEPTH; k++) begin
                        owe_beat(KIND_BYTE, payload_mem[k], (k + 1 == frame_len));
                    end
                end
                restart_hunt();
            end
            default: begin
                restart_hunt();
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            first_hdr = FIRST_HEADER_RESET;
            second_hdr = SECOND_HEADER_RESET;
            tail_val = TAIL_RESET;
            restart_hunt();
            owed_beats.delete();
        end else begin
            // Result beats come from earlier input beats, so they are checked first.
            if (m_valid && m_ready) begin
                if (owed_beats.size() == 0) begin
                    $error("Result beat with nothing owed: kind %0d, payload_byte 0x%02h, last %0b",
                           m_kind, m_payload_byte, m_last);
                    errors++;
                end else begin
                    want = owed_beats.pop_front();
                    if (m_kind !== want.kind) begin
                        $error("kind mismatch: expected %0d, actual %0d", want.kind, m_kind);
                        errors++;
                    end
                    if (m_payload_byte !== want.payload_byte) begin
                        $error("payload_byte mismatch: expected 0x%02h, actual 0x%02h",
                               want.payload_byte, m_payload_byte);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last mismatch: expected %0b, actual %0b", want.last, m_last);
                        errors++;
                    end
                end
            end

            // Register writes; the unmapped index is ignored.
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FIRST_HEADER:  first_hdr = cfg_wdata;
                    CFG_SECOND_HEADER: second_hdr = cfg_wdata;
                    CFG_TAIL:          tail_val = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) parse_rx_byte(s_rx_byte);
        end
        mismatch_count <= errors;
        beats_outstanding <= owed_beats.size();
    end

endmodule

FILE: tb/tb_header_length_tail_frame_parser.sv
`timescale 1ns / 1ps

module tb_header_length_tail_frame_parser;
    import hltfp_pkg::*;

    localparam int         PAYLOAD_DEPTH = 64;
    localparam int         CYCLE_LIMIT   = 8_000_000;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         PHASE_BEATS   = 75;
    localparam cfg_index_t CFG_UNMAPPED  = 2'd3;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    kind_t      m_kind;
    logic [7:0] m_payload_byte;
    logic       m_last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = CFG_FIRST_HEADER;
    logic [7:0] cfg_wdata = 8'h00;

    int         mismatch_count;
    int         beats_outstanding;
    int         cycle_count = 0;
    int         burst_left = 0;
    int         bytes_sent = 0;
    logic [7:0] hdr_first = FIRST_HEADER_RESET;
    logic [7:0] hdr_second = SECOND_HEADER_RESET;
    logic [7:0] hdr_tail = TAIL_RESET;
    logic [31:0] ready_pattern = '1;
    int          pattern_pos = 0;

    always #10 aclk = ~aclk;

    header_length_tail_frame_parser #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) uut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_payload_byte(m_payload_byte),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    hltfp_frame_monitor #(
        .PAYLOAD_DEPTH(PAYLOAD_DEPTH)
    ) monitor (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_rx_byte(s_rx_byte),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_payload_byte(m_payload_byte),
        .m_last(m_last),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .mismatch_count(mismatch_count),
        .beats_outstanding(beats_outstanding)
    );

    // Watchdog in case the parser hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // The receiver follows a 32-bit ready pattern that is redrawn each time it wraps.
    always @(posedge aclk) begin
        if (pattern_pos == 31) begin
            pattern_pos <= 0;
            case ($urandom_range(0, 3))
                0:       ready_pattern <= '1;
                1:       ready_pattern <= $urandom;
                2:       ready_pattern <= $urandom & $urandom;
                default: ready_pattern <= $urandom | $urandom;
            endcase
        end else begin
            pattern_pos <= pattern_pos + 1;
        end
        m_ready <= ready_pattern[pattern_pos];
    end

    // Sends one input beat; the sender runs in bursts with random gaps between them.
    task automatic send_byte(input logic [7:0] b);
        if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        bytes_sent++;
    endtask

    // Holds the sender until every owed result has come and the parser has settled.
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (beats_outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Writes all registers back to back, then drops valid once.
    task automatic load_registers(input logic [7:0] first, input logic [7:0] second,
                                  input logic [7:0] tail);
        write_reg(CFG_FIRST_HEADER, first);
        write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
        write_reg(CFG_SECOND_HEADER, second);
        write_reg(CFG_TAIL, tail);
        cfg_valid <= 1'b0;
        hdr_first = first;
        hdr_second = second;
        hdr_tail = tail;
    endtask

    // Mostly short frames, now and then empty, long, full-depth or oversized ones.
    function automatic logic [7:0] pick_length();
        case ($urandom_range(0, 19))
            0:       return 8'(PAYLOAD_DEPTH);
            1:       return 8'($urandom_range(PAYLOAD_DEPTH + 1, 255));
            2:       return 8'd0;
            3, 4:    return 8'($urandom_range(9, PAYLOAD_DEPTH - 1));
            default: return 8'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic send_frame(input logic [7:0] len, input bit good_tail);
        int i;
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(len);
        if (len <= PAYLOAD_DEPTH) begin
            for (i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)));
            send_byte(good_tail ? hdr_tail : hdr_tail ^ 8'($urandom_range(1, 255)));
        end
    endtask

    // Mostly well-formed frames, with bad tails, broken headers, noise and cut frames.
    task automatic run_random_traffic(input int beat_count);
        int stop_at;
        int choice;
        int n;
        stop_at = bytes_sent + beat_count;
        while (bytes_sent < stop_at) begin
            choice = $urandom_range(0, 39);
            if (choice == 0) begin
                drain();
            end else if (choice < 26) begin
                send_frame(pick_length(), 1'b1);
            end else if (choice < 30) begin
                send_frame(pick_length(), 1'b0);
            end else if (choice < 33) begin
                send_byte(hdr_first);
                send_byte(hdr_second ^ 8'($urandom_range(1, 255)));
            end else if (choice < 36) begin
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                // A frame cut short: the next bytes are taken as its payload and tail.
                send_byte(hdr_first);
                send_byte(hdr_second);
                n = $urandom_range(2, 8);
                send_byte(8'(n));
                repeat ($urandom_range(1, n - 1)) send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        int phase_idx;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty frame.
        send_frame(8'd0, 1'b1);
        // Lengths just above the depth and at the top of the field.
        send_frame(8'(PAYLOAD_DEPTH + 1), 1'b1);
        send_frame(8'hFF, 1'b1);
        // Broken header: the first header byte again in the second slot is not
        // taken as a new start, so the second header byte after it is quiet.
        send_byte(hdr_first);
        send_byte(hdr_first);
        send_byte(hdr_second);
        // One-byte frame with the lowest payload value.
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(hdr_tail);
        // Two-byte frame with the highest payload value and a wrong tail.
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(hdr_tail ^ 8'h80);

        run_random_traffic(PHASE_BEATS);

        for (phase_idx = 1; phase_idx <= 5; phase_idx++) begin
            drain();
            case (phase_idx)
                1:       load_registers(8'h00, 8'hFF, 8'h00);
                2:       load_registers(8'hFF, 8'h00, 8'hFF);
                3:       load_registers(8'hFF, 8'hFF, 8'hFF);
                4:       load_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                        8'($urandom_range(0, 255)));
                default: load_registers(FIRST_HEADER_RESET, SECOND_HEADER_RESET, TAIL_RESET);
            endcase
            run_random_traffic(PHASE_BEATS);
        end

        drain();
        if (mismatch_count == 0 && beats_outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
